[hdl/plc_builtin_int_conversion_alu_core_assert.svh]
// assertion macros for the integer and conversion alu
// used by the checker module, no other dependencies
`ifndef PLC_BUILTIN_INT_CONVERSION_ALU_CORE_ASSERT_SVH
`define PLC_BUILTIN_INT_CONVERSION_ALU_CORE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hdl/pba_pkg.sv]
// package for the integer and conversion alu: opcodes, widths, constants
// no dependencies
`default_nettype none
package pba_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned FUNC_W = 5;
    localparam int unsigned HALF_W = 16;

    localparam logic [FUNC_W-1:0] F_ABS = 5'd0;
    localparam logic [FUNC_W-1:0] F_MIN = 5'd1;
    localparam logic [FUNC_W-1:0] F_MAX = 5'd2;
    localparam logic [FUNC_W-1:0] F_SUM = 5'd3;
    localparam logic [FUNC_W-1:0] F_LIMIT = 5'd4;
    localparam logic [FUNC_W-1:0] F_SEL = 5'd5;
    localparam logic [FUNC_W-1:0] F_MUX = 5'd6;
    localparam logic [FUNC_W-1:0] F_ROL = 5'd7;
    localparam logic [FUNC_W-1:0] F_ROR = 5'd8;
    localparam logic [FUNC_W-1:0] F_ROUND = 5'd9;
    localparam logic [FUNC_W-1:0] F_TRUNC = 5'd10;
    localparam logic [FUNC_W-1:0] F_FLOOR = 5'd11;
    localparam logic [FUNC_W-1:0] F_CEIL = 5'd12;
    localparam logic [FUNC_W-1:0] F_R2I = 5'd13;
    localparam logic [FUNC_W-1:0] F_I2R = 5'd14;
    localparam logic [FUNC_W-1:0] F_B2I = 5'd15;
    localparam logic [FUNC_W-1:0] F_I2B = 5'd16;
    localparam logic [FUNC_W-1:0] F_D2I = 5'd17;
    localparam logic [FUNC_W-1:0] F_I2D = 5'd18;

    localparam logic [HALF_W-1:0] HALF_MAX = 16'h7FFF;
    localparam logic [HALF_W-1:0] HALF_MIN = 16'h8000;

    // float rounding modes
    localparam logic [1:0] RM_HALF = 2'd0;
    localparam logic [1:0] RM_TRUNC = 2'd1;
    localparam logic [1:0] RM_FLOOR = 2'd2;
    localparam logic [1:0] RM_CEIL = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] arg_a;
        logic [WORD_W-1:0] arg_b;
        logic [WORD_W-1:0] arg_c;
        logic [WORD_W-1:0] arg_d;
        logic              wide;
    } t_req;

    function automatic logic [WORD_W-1:0] sx16(input logic [HALF_W-1:0] v);
        return {{(WORD_W-HALF_W){v[HALF_W-1]}}, v};
    endfunction
endpackage
`default_nettype wire

[hdl/pba_if.sv]
// valid/ready channel interfaces for request and result transactions
// depends on pba_pkg
`default_nettype none
interface pba_req_if;
    logic           valid;
    logic           ready;
    pba_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pba_res_if;
    logic                          valid;
    logic                          ready;
    logic [pba_pkg::WORD_W-1:0]    result;
    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface
`default_nettype wire

[hdl/pba_f2i.sv]
// float32 to int16 converter, three pipeline stages with stall enable
// depends on pba_pkg
`default_nettype none
module pba_f2i (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [pba_pkg::WORD_W-1:0]  i_bits,
    input  wire logic [1:0]                  i_mode,
    output logic      [pba_pkg::HALF_W-1:0]  o_val
);
    // stage 1: classify
    logic        r_s1_nan, r_s1_big, r_s1_sign, r_s1_zero;
    logic [1:0]  r_s1_mode;
    logic [7:0]  r_s1_exp;
    logic [23:0] r_s1_man;
    // stage 2: aligned integer and fraction flags
    logic        r_s2_nan, r_s2_big, r_s2_sign, r_s2_inc, r_s2_frac_nz;
    logic [1:0]  r_s2_mode;
    logic [16:0] r_s2_int;
    logic [15:0] r_s2_res;

    logic [7:0]  w_exp;
    logic [63:0] w_sh;
    logic [4:0]  w_amt;
    logic        w_half, w_rest;

    assign w_exp = i_bits[30:23];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_nan  <= (w_exp == 8'hFF) && (i_bits[22:0] != 23'd0);
            // |x| >= 32768 saturates (covers > 40000 and inf too)
            r_s1_big  <= (w_exp >= 8'd142);
            r_s1_sign <= i_bits[31];
            r_s1_zero <= (w_exp == 8'd0);
            r_s1_exp  <= w_exp;
            r_s1_man  <= {1'b1, i_bits[22:0]};
            r_s1_mode <= i_mode;
        end
    end

    // align: value = man * 2^(exp-150); place binary point at bit 32
    always_comb begin
        w_amt = 5'(r_s1_exp - 8'd118);
        if (r_s1_zero || r_s1_exp < 8'd95) begin
            w_sh = 64'd0;
        end else if (r_s1_exp >= 8'd118) begin
            w_sh = {40'd0, r_s1_man} << w_amt;
        end else begin
            w_sh = {40'd0, r_s1_man} >> (8'd118 - r_s1_exp);
        end
        w_half = w_sh[31];
        // subnormals and tiny normals still carry a nonzero fraction
        w_rest = (|w_sh[30:0])
               | (r_s1_zero ? (|r_s1_man[22:0]) : (r_s1_exp < 8'd95));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_nan     <= r_s1_nan;
            r_s2_big     <= r_s1_big;
            r_s2_sign    <= r_s1_sign;
            r_s2_mode    <= r_s1_mode;
            r_s2_int     <= w_sh[48:32];
            r_s2_frac_nz <= w_half | w_rest;
            r_s2_inc     <= w_half;
        end
    end

    // round and saturate magnitude, then apply sign
    logic        w_up;
    logic [16:0] w_mag;
    always_comb begin
        case (r_s2_mode)
            pba_pkg::RM_HALF:  w_up = r_s2_inc;
            pba_pkg::RM_FLOOR: w_up = r_s2_sign & r_s2_frac_nz;
            pba_pkg::RM_CEIL:  w_up = ~r_s2_sign & r_s2_frac_nz;
            default:           w_up = 1'b0;
        endcase
        w_mag = r_s2_int + {16'd0, w_up};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_s2_nan) begin
                r_s2_res <= 16'd0;
            end else if (r_s2_sign) begin
                r_s2_res <= (r_s2_big || w_mag > 17'd32768) ? pba_pkg::HALF_MIN
                                                            : 16'(17'd0 - w_mag);
            end else begin
                r_s2_res <= (r_s2_big || w_mag > 17'd32767) ? pba_pkg::HALF_MAX
                                                            : w_mag[15:0];
            end
        end
    end
    assign o_val = r_s2_res;
endmodule
`default_nettype wire

[hdl/pba_int_unit.sv]
// integer ops, rotates and simple conversions, three pipeline stages
// depends on pba_pkg
`default_nettype none
module pba_int_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire pba_pkg::t_req               i_req,
    output logic      [pba_pkg::WORD_W-1:0]  o_res
);
    logic [pba_pkg::WORD_W-1:0] r_s1, r_s2, r_s3;
    logic [pba_pkg::WORD_W-1:0] w_r;
    logic signed [15:0] ia, ib, ic;
    logic [15:0] w_abs, w_v16, w_rot16;
    logic [31:0] w_rot32, w_flt;
    logic [3:0]  s16;
    logic [4:0]  s32, w_lz;
    logic [15:0] w_mag;
    logic        w_found;

    always_comb begin
        ia = i_req.arg_a[15:0];
        ib = i_req.arg_b[15:0];
        ic = i_req.arg_c[15:0];
        w_abs = (ia == $signed(pba_pkg::HALF_MIN)) ? pba_pkg::HALF_MAX
              : (ia < 0 ? 16'(-ia) : 16'(ia));
        w_v16 = i_req.arg_a[15:0];
        s16 = i_req.arg_b[3:0];
        s32 = i_req.arg_b[4:0];
        if (i_req.func == pba_pkg::F_ROL) begin
            w_rot16 = 16'({w_v16, w_v16} << s16 >> 16);
            w_rot32 = 32'({i_req.arg_a, i_req.arg_a} << s32 >> 32);
        end else begin
            w_rot16 = 16'({w_v16, w_v16} >> s16);
            w_rot32 = 32'({i_req.arg_a, i_req.arg_a} >> s32);
        end
        // int16 to float: magnitude, leading one, exponent
        w_mag = ia[15] ? 16'(-ia) : 16'(ia);
        w_lz = 5'd0;
        w_found = 1'b0;
        for (int k = 15; k >= 0; k--) begin
            if (!w_found && w_mag[k]) begin
                w_lz = 5'(k);
                w_found = 1'b1;
            end
        end
        if (w_mag == 16'd0) begin
            w_flt = 32'd0;
        end else begin
            w_flt = {ia[15], 8'(8'd127 + {3'd0, w_lz}),
                     23'({w_mag, 23'd0} >> w_lz)};
        end
        case (i_req.func)
            pba_pkg::F_ABS:   w_r = pba_pkg::sx16(w_abs);
            pba_pkg::F_MIN:   w_r = pba_pkg::sx16(ia < ib ? ia : ib);
            pba_pkg::F_MAX:   w_r = pba_pkg::sx16(ia > ib ? ia : ib);
            pba_pkg::F_SUM:   w_r = pba_pkg::sx16(16'(ia + ib));
            pba_pkg::F_LIMIT: w_r = pba_pkg::sx16(ib < ia ? ia : (ib > ic ? ic : ib));
            pba_pkg::F_SEL:   w_r = (i_req.arg_a != 32'd0) ? i_req.arg_c : i_req.arg_b;
            pba_pkg::F_MUX:   w_r = (ia == 16'sd1) ? i_req.arg_c
                                  : (ia == 16'sd2) ? i_req.arg_d : i_req.arg_b;
            pba_pkg::F_ROL, pba_pkg::F_ROR:
                w_r = i_req.wide ? w_rot32 : pba_pkg::sx16(w_rot16);
            pba_pkg::F_I2R:   w_r = w_flt;
            pba_pkg::F_B2I:   w_r = {31'd0, i_req.arg_a != 32'd0};
            pba_pkg::F_I2B:   w_r = {31'd0, ia != 16'sd0};
            pba_pkg::F_D2I:   w_r = (i_req.arg_a > 32'd32767) ? pba_pkg::sx16(pba_pkg::HALF_MAX)
                                                          : i_req.arg_a;
            pba_pkg::F_I2D:   w_r = pba_pkg::sx16(ia);
            default:          w_r = 32'd0;
        endcase
    end

    // delay line to match the float converter latency
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= w_r;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end
    assign o_res = r_s3;
endmodule
`default_nettype wire

[hdl/plc_builtin_int_conversion_alu_core.sv]
// integer and conversion builtin execute unit, top level
// depends on pba_pkg, pba_if, pba_int_unit, pba_f2i
//
// usage:
//   i_req carries one request transaction (func, four operand words, wide);
//   o_res carries one 32-bit result transaction per request, in order.
//   an accepted request is registered through r_vld[0], r_vld[1] and r_vld[2] on its way to o_res.valid.
//   throughput is one transaction per cycle unless the receiver stalls: the
//   pipeline holds three items and moves as a whole; ready to the sender is
//   high whenever the output slot is empty or being taken this cycle.
//   the float path (classify, align, round/saturate) sets the stage count.
//   the integer path computes in the first stage and is delayed to match.
//   a receiver stall freezes all stages; nothing is lost or repeated.
//   reset (synchronous, active low) clears all valid bits; payload is
//   left as is.
//   unknown opcodes return 0.
`default_nettype none
module plc_builtin_int_conversion_alu_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pba_req_if.sink     i_req,
    pba_res_if.source   o_res
);
    logic [2:0] r_vld;
    logic       w_en;
    logic       w_is_flt;
    logic [1:0] w_mode;
    logic [pba_pkg::WORD_W-1:0] w_int;
    logic [pba_pkg::HALF_W-1:0] w_f16;
    logic [2:0] r_flt;

    // pipeline advances when output slot is free or being taken
    assign w_en = ~r_vld[2] | o_res.ready;
    assign i_req.ready = w_en;

    always_comb begin
        w_is_flt = 1'b1;
        case (i_req.data.func)
            pba_pkg::F_ROUND: w_mode = pba_pkg::RM_HALF;
            pba_pkg::F_TRUNC, pba_pkg::F_R2I: w_mode = pba_pkg::RM_TRUNC;
            pba_pkg::F_FLOOR: w_mode = pba_pkg::RM_FLOOR;
            pba_pkg::F_CEIL:  w_mode = pba_pkg::RM_CEIL;
            default: begin
                w_mode = pba_pkg::RM_TRUNC;
                w_is_flt = 1'b0;
            end
        endcase
    end

    pba_int_unit u_int (
        .i_clk (i_clk), .i_en (w_en), .i_req (i_req.data), .o_res (w_int)
    );
    pba_f2i u_f2i (
        .i_clk (i_clk), .i_en (w_en), .i_bits (i_req.data.arg_a),
        .i_mode (w_mode), .o_val (w_f16)
    );

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 3'd0;
        end else if (w_en) begin
            r_vld <= {r_vld[1:0], i_req.valid};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flt <= {r_flt[1:0], w_is_flt};
        end
    end

    assign o_res.valid  = r_vld[2];
    assign o_res.result = r_flt[2] ? pba_pkg::sx16(w_f16) : w_int;
endmodule
`default_nettype wire

[hdl/pba_checker.sv]
// port-level checker for the alu top level, with bind
// depends on pba_pkg and the assertion macro header
`default_nettype none
`include "plc_builtin_int_conversion_alu_core_assert.svh"
module pba_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [pba_pkg::WORD_W-1:0]  i_out_result
);
    // a stalled result holds
    `PBA_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_result))
    // ready is low only while a result waits
    `PBA_ASSERT_IMP(a_rdy, i_clk, i_rst_n, !i_in_ready, i_out_valid)
    // an accepted transaction reaches the output if i_in_ready stays high as it moves through the pipeline
    `PBA_ASSERT_IMP(a_lat, i_clk, i_rst_n,
        i_in_valid && i_in_ready ##1 i_in_ready ##1 i_in_ready, ##1 i_out_valid)
endmodule

bind plc_builtin_int_conversion_alu_core pba_checker u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n),
    .i_in_valid (i_req.valid), .i_in_ready (i_req.ready),
    .i_out_valid (o_res.valid), .i_out_ready (o_res.ready),
    .i_out_result (o_res.result)
);
`default_nettype wire

[test/plc_builtin_int_conversion_alu_core_tb.sv]
// self-checking testbench for the integer and conversion alu core
// depends on pba_pkg, pba_if and the core; directed then random traffic with idling
`default_nettype none
module plc_builtin_int_conversion_alu_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 500;
    localparam int STALL_LIMIT = 2000;
    localparam int WORD_W = pba_pkg::WORD_W;
    localparam int FUNC_W = pba_pkg::FUNC_W;

    logic i_clk;
    logic i_rst_n;
    pba_req_if req_if ();
    pba_res_if res_if ();

    plc_builtin_int_conversion_alu_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    pba_pkg::t_req     pending_reqs[$];
    logic [WORD_W-1:0] expected_words[$];
    int                n_errors;
    int                n_total;
    int                n_taken;
    int                quiet_cycles;
    logic              req_taken;
    int                send_idle_pct;
    int                recv_stall_pct;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // golden arithmetic
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] sat_word(input int v);
        if (v > 32767) return pba_pkg::sx16(pba_pkg::HALF_MAX);
        if (v < -32768) return pba_pkg::sx16(pba_pkg::HALF_MIN);
        return WORD_W'(v);
    endfunction

    // float32 bits to int16 with the given rounding mode
    function automatic logic [WORD_W-1:0] float_to_half(input logic [31:0] bits,
                                                       input logic [1:0] mode);
        int   ex;
        real  x;
        real  frac;
        int   t;
        ex = int'(bits[30:23]);
        if (ex == 255) begin
            if (bits[22:0] != 0) return '0;
            return bits[31] ? pba_pkg::sx16(pba_pkg::HALF_MIN)
                            : pba_pkg::sx16(pba_pkg::HALF_MAX);
        end
        if (ex == 0) x = real'(bits[22:0]) * 2.0 ** (-149);
        else x = real'({1'b1, bits[22:0]}) * 2.0 ** (ex - 150);
        if (bits[31]) x = -x;
        if (x > 40000.0) return pba_pkg::sx16(pba_pkg::HALF_MAX);
        if (x < -40000.0) return pba_pkg::sx16(pba_pkg::HALF_MIN);
        t = $rtoi(x);
        frac = x - real'(t);
        case (mode)
            pba_pkg::RM_HALF: begin
                if (frac >= 0.5) t++;
                else if (frac <= -0.5) t--;
            end
            pba_pkg::RM_FLOOR: if (frac < 0.0) t--;
            pba_pkg::RM_CEIL: if (frac > 0.0) t++;
            default: ;
        endcase
        return sat_word(t);
    endfunction

    // int16 to float32 bits, always exact
    function automatic logic [WORD_W-1:0] half_to_float(input logic signed [15:0] v);
        logic [16:0] mag;
        int          p;
        logic [31:0] m;
        if (v == 0) return '0;
        mag = v < 0 ? 17'(-int'(v)) : 17'(v);
        p = 0;
        for (int i = 0; i < 17; i++) if (mag[i]) p = i;
        m = 32'(mag) << (23 - p);
        return {v[15], 8'(127 + p), m[22:0]};
    endfunction

    function automatic logic [WORD_W-1:0] rotate_word(input pba_pkg::t_req r,
                                                     input logic left);
        logic [31:0] v32;
        logic [15:0] v16;
        int          s;
        v32 = r.arg_a;
        v16 = r.arg_a[15:0];
        if (r.wide) begin
            s = int'(r.arg_b[4:0]);
            if (s == 0) return v32;
            return left ? (v32 << s) | (v32 >> (32 - s)) : (v32 >> s) | (v32 << (32 - s));
        end
        s = int'(r.arg_b[3:0]);
        if (s != 0)
            v16 = left ? (v16 << s) | (v16 >> (16 - s)) : (v16 >> s) | (v16 << (16 - s));
        return pba_pkg::sx16(v16);
    endfunction

    function automatic logic [WORD_W-1:0] alu_result(input pba_pkg::t_req r);
        logic signed [15:0] ia;
        logic signed [15:0] ib;
        logic signed [15:0] ic;
        ia = r.arg_a[15:0];
        ib = r.arg_b[15:0];
        ic = r.arg_c[15:0];
        case (r.func)
            pba_pkg::F_ABS: return ia == pba_pkg::HALF_MIN ? pba_pkg::sx16(pba_pkg::HALF_MAX)
                                                            : pba_pkg::sx16(ia < 0 ? -ia : ia);
            pba_pkg::F_MIN: return pba_pkg::sx16(ia < ib ? ia : ib);
            pba_pkg::F_MAX: return pba_pkg::sx16(ia > ib ? ia : ib);
            pba_pkg::F_SUM: return pba_pkg::sx16(16'(ia + ib));
            pba_pkg::F_LIMIT: begin
                if (ib < ia) return pba_pkg::sx16(ia);
                if (ib > ic) return pba_pkg::sx16(ic);
                return pba_pkg::sx16(ib);
            end
            pba_pkg::F_SEL: return r.arg_a != 0 ? r.arg_c : r.arg_b;
            pba_pkg::F_MUX: begin
                if (ia == 1) return r.arg_c;
                if (ia == 2) return r.arg_d;
                return r.arg_b;
            end
            pba_pkg::F_ROL: return rotate_word(r, 1'b1);
            pba_pkg::F_ROR: return rotate_word(r, 1'b0);
            pba_pkg::F_ROUND: return float_to_half(r.arg_a, pba_pkg::RM_HALF);
            pba_pkg::F_TRUNC, pba_pkg::F_R2I: return float_to_half(r.arg_a, pba_pkg::RM_TRUNC);
            pba_pkg::F_FLOOR: return float_to_half(r.arg_a, pba_pkg::RM_FLOOR);
            pba_pkg::F_CEIL: return float_to_half(r.arg_a, pba_pkg::RM_CEIL);
            pba_pkg::F_I2R: return half_to_float(ia);
            pba_pkg::F_B2I: return r.arg_a != 0 ? 32'd1 : 32'd0;
            pba_pkg::F_I2B: return ia != 0 ? 32'd1 : 32'd0;
            pba_pkg::F_D2I: return r.arg_a > 32'(pba_pkg::HALF_MAX)
                                   ? pba_pkg::sx16(pba_pkg::HALF_MAX) : r.arg_a;
            pba_pkg::F_I2D: return pba_pkg::sx16(ia);
            default: return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rand_int_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_8000;
            1: return 32'h0000_7FFF;
            2: return $urandom_range(0, 4);
            3: return 32'($urandom) | 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // float bits mostly in and around the int16 range
    function automatic logic [31:0] rand_float_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 9))
            0: w[30:23] = 8'hFF;
            1: w[30:23] = 8'h00;
            2: w[30:0] = {8'($urandom_range(120, 128)), 1'b0, 22'($urandom_range(0, 3)) << 20};
            3, 4: ;
            default: w[30:23] = 8'($urandom_range(118, 145));
        endcase
        return w;
    endfunction

    function automatic pba_pkg::t_req make_req(input logic [FUNC_W-1:0] f,
                                               input logic [31:0] a,
                                               input logic [31:0] b, input logic [31:0] c,
                                               input logic [31:0] d, input logic w);
        pba_pkg::t_req r;
        r.func = f;
        r.arg_a = a;
        r.arg_b = b;
        r.arg_c = c;
        r.arg_d = d;
        r.wide = w;
        return r;
    endfunction

    function automatic pba_pkg::t_req rand_req();
        pba_pkg::t_req r;
        r.func = $urandom_range(0, 9) == 0 ? FUNC_W'($urandom_range(19, 31))
                                           : FUNC_W'($urandom_range(0, 18));
        r.arg_a = rand_int_word();
        r.arg_b = rand_int_word();
        r.arg_c = rand_int_word();
        r.arg_d = $urandom;
        r.wide = 1'($urandom_range(0, 1));
        if (r.func >= pba_pkg::F_ROUND && r.func <= pba_pkg::F_R2I)
            r.arg_a = rand_float_word();
        if (r.func == pba_pkg::F_MUX && $urandom_range(0, 1))
            r.arg_a[15:0] = 16'($urandom_range(0, 3));
        if ((r.func == pba_pkg::F_SEL || r.func == pba_pkg::F_B2I) && $urandom_range(0, 2) == 0)
            r.arg_a = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        n_errors = 0;
        // directed corner transactions
        pending_reqs.push_back(make_req(pba_pkg::F_ABS, 32'h0000_8000, 0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_ABS, 32'hFFFF_FFFB, 0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_MIN, 32'h0000_8000, 32'h0000_7FFF,
                                        0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_MAX, 32'h0000_8000, 32'h0000_7FFF,
                                        0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_SUM, 32'h0000_7FFF, 32'h0000_0001,
                                        0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_LIMIT, 32'd10, 32'd5, 32'd20, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_LIMIT, 32'd30, 32'd25, 32'd20, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_LIMIT, 32'd10, 32'hFFFF_0040, 32'd20,
                                        0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_SEL, 32'h0001_0000, 32'h1111, 32'h2222,
                                        0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_SEL, 32'h0, 32'hFFFF_FFFF, 32'h2222,
                                        0, 1'b0));
        for (int i = 0; i < 4; i++)
            pending_reqs.push_back(make_req(pba_pkg::F_MUX, 32'hABCD_0000 | i, 32'hB, 32'hC,
                                            32'hD, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_ROL, 32'h8001_8001, 32'h0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_ROL, 32'h8001_8001, 32'hFFFF_FFFF,
                                        0, 0, 1'b1));
        pending_reqs.push_back(make_req(pba_pkg::F_ROR, 32'h0000_0001, 32'h0000_FFFF,
                                        0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_ROUND, 32'h4020_0000, 0, 0, 0, 1'b0)); // 2.5
        pending_reqs.push_back(make_req(pba_pkg::F_ROUND, 32'hC020_0000, 0, 0, 0, 1'b0)); // -2.5
        pending_reqs.push_back(make_req(pba_pkg::F_TRUNC, 32'h7FC0_0000, 0, 0, 0, 1'b0)); // nan
        pending_reqs.push_back(make_req(pba_pkg::F_FLOOR, 32'hFF80_0000, 0, 0, 0, 1'b0)); // -inf
        pending_reqs.push_back(make_req(pba_pkg::F_CEIL, 32'h7F80_0000, 0, 0, 0, 1'b0));  // +inf
        pending_reqs.push_back(make_req(pba_pkg::F_FLOOR, 32'hBFC0_0000, 0, 0, 0, 1'b0)); // -1.5
        // tiny negative normal and positive subnormal
        pending_reqs.push_back(make_req(pba_pkg::F_FLOOR, 32'h8080_0000, 0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_CEIL, 32'h0000_0001, 0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_R2I, 32'h46FF_FF33, 0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_I2R, 32'h0000_8000, 0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(pba_pkg::F_D2I, 32'hFFFF_FFFF, 0, 0, 0, 1'b0));
        pending_reqs.push_back(make_req(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, 1'b1));
        for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(rand_req());
        n_total = pending_reqs.size();

        // wait for the drain, then a latency margin
        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (expected_words.size() != 0 || req_if.valid) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && expected_words.size() == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // reset, request driver and result ready, all on the falling edge
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // idle profile follows progress through the stimulus
    always_comb begin
        case ((4 * n_taken) / (n_total > 0 ? n_total : 1))
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 68; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 68; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
        endcase
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!req_if.valid || req_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req_if.valid <= 1'b1;
                    req_if.data <= pending_reqs.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on request transaction, check on result transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        logic              any_move;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            n_taken <= 0;
            quiet_cycles <= 0;
        end else begin
            any_move = 1'b0;
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                expected_words.push_back(alu_result(req_if.data));
                n_taken <= n_taken + 1;
                any_move = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                any_move = 1'b1;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result transaction, got %08h", $time,
                             res_if.result);
                    n_errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (res_if.result !== want) begin
                        $display("%0t: result mismatch, expected %08h got %08h", $time,
                                 want, res_if.result);
                        n_errors++;
                    end
                end
            end
            // watchdog on cycles without any transaction
            if (any_move) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/pba_pkg.sv
hdl/pba_if.sv
hdl/pba_f2i.sv
hdl/pba_int_unit.sv
hdl/plc_builtin_int_conversion_alu_core.sv
hdl/pba_checker.sv
test/plc_builtin_int_conversion_alu_core_tb.sv
